// ===== rtl/cgf_pkg.sv =====
package cgf_pkg;

  typedef enum logic [0:0] {
    REQ_ENQ = 1'b0,
    REQ_DEQ = 1'b1
  } cgf_req_e;

  typedef enum logic [1:0] {
    STATUS_SERVED  = 2'd0,
    STATUS_EMPTY   = 2'd1,
    STATUS_DROPPED = 2'd2
  } cgf_status_e;

  localparam int unsigned ClassBits = 3;
  localparam int unsigned RollBits  = 16;

  typedef struct packed {
    cgf_req_e              req_type;
    logic [ClassBits-1:0]  class_id;
    logic [RollBits-1:0]   roll_number;
  } cgf_in_t;

  typedef struct packed {
    logic [ClassBits-1:0]  out_class;
    logic [RollBits-1:0]   out_roll;
    cgf_status_e           status;
  } cgf_out_t;

  // Decision for one accepted request, from the pointer control to the top level
  typedef struct packed {
    logic                  wr_en;
    logic                  rd_en;
    logic                  result;
    cgf_status_e           status;
    logic [ClassBits-1:0]  cls;
    logic [RollBits-1:0]   echo_roll;
  } cgf_ctrl_t;

endpackage

// ===== rtl/cgf_store.sv =====
module cgf_store #(
  parameter int unsigned Depth = 80,
  parameter int unsigned AddrW = 7,
  parameter int unsigned DataW = 16
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [DataW-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [DataW-1:0] rd_data_o
);

  logic [DataW-1:0] mem [Depth];
  logic [DataW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== rtl/cgf_ctrl.sv =====
module cgf_ctrl #(
  parameter int unsigned NumClasses = 5,
  parameter int unsigned ClassDepth = 16,
  parameter int unsigned AddrW      = 7
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  cgf_pkg::cgf_in_t   req_i,
  output cgf_pkg::cgf_ctrl_t ctrl_o,
  output logic [AddrW-1:0]   wr_addr_o,
  output logic [AddrW-1:0]   rd_addr_o
);

  localparam int unsigned CW   = (NumClasses > 1) ? $clog2(NumClasses) : 1;
  localparam int unsigned OCW  = $clog2(NumClasses + 1);
  localparam int unsigned PTRW = $clog2(ClassDepth);
  localparam int unsigned CNTW = $clog2(ClassDepth + 1);

  logic [CW-1:0]   class_order_q [NumClasses];
  logic [CW-1:0]   order_head_q, order_head_d;
  logic [OCW-1:0]  order_count_q, order_count_d;
  logic [CW-1:0]   order_tail;
  logic [PTRW-1:0] class_head_q  [NumClasses];
  logic [CNTW-1:0] class_count_q [NumClasses];

  logic [CW-1:0]   enq_cls;
  logic [CW-1:0]   deq_cls;
  logic            enq_ok;
  logic            deq_ok;
  logic [PTRW-1:0] wr_pos;
  int unsigned     pos_sum;
  int unsigned     tail_sum;

  always_comb begin
    enq_cls  = CW'(req_i.class_id);
    deq_cls  = class_order_q[order_head_q];
    enq_ok   = (32'(req_i.class_id) < NumClasses)
               && (class_count_q[enq_cls] != CNTW'(ClassDepth));
    deq_ok   = (order_count_q != '0) && (32'(deq_cls) < NumClasses)
               && (class_count_q[deq_cls] != '0);

    pos_sum  = 32'(class_head_q[enq_cls]) + 32'(class_count_q[enq_cls]);
    if (pos_sum >= ClassDepth) begin
      pos_sum = pos_sum - ClassDepth;
    end
    wr_pos   = PTRW'(pos_sum);

    tail_sum = 32'(order_head_q) + 32'(order_count_q);
    if (tail_sum >= NumClasses) begin
      tail_sum = tail_sum - NumClasses;
    end
    order_tail = CW'(tail_sum);

    wr_addr_o = AddrW'(32'(enq_cls) * ClassDepth + 32'(wr_pos));
    rd_addr_o = AddrW'(32'(deq_cls) * ClassDepth + 32'(class_head_q[deq_cls]));
  end

  always_comb begin
    ctrl_o        = '0;
    ctrl_o.status = cgf_pkg::STATUS_SERVED;
    if (req_i.req_type == cgf_pkg::REQ_ENQ) begin
      ctrl_o.wr_en = enq_ok;
      if (!enq_ok) begin
        ctrl_o.result    = 1'b1;
        ctrl_o.status    = cgf_pkg::STATUS_DROPPED;
        ctrl_o.cls       = req_i.class_id;
        ctrl_o.echo_roll = req_i.roll_number;
      end
    end else begin
      ctrl_o.result = 1'b1;
      ctrl_o.rd_en  = deq_ok;
      if (deq_ok) begin
        ctrl_o.cls = cgf_pkg::ClassBits'(deq_cls);
      end else begin
        ctrl_o.status = cgf_pkg::STATUS_EMPTY;
      end
    end
  end

  // Order ring: a class leaves at the head once its FIFO drains
  always_comb begin
    order_head_d  = order_head_q;
    order_count_d = order_count_q;
    if (ctrl_o.wr_en && class_count_q[enq_cls] == '0) begin
      order_count_d = order_count_q + 1'b1;
    end
    if (ctrl_o.rd_en && class_count_q[deq_cls] == CNTW'(1)) begin
      order_head_d  = (order_head_q == CW'(NumClasses - 1)) ? '0 : order_head_q + 1'b1;
      order_count_d = order_count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_head_q  <= '0;
      order_count_q <= '0;
      for (int i = 0; i < NumClasses; i++) begin
        class_head_q[i]  <= '0;
        class_count_q[i] <= '0;
      end
    end else if (accept_i) begin
      order_head_q  <= order_head_d;
      order_count_q <= order_count_d;
      if (ctrl_o.wr_en) begin
        class_count_q[enq_cls] <= class_count_q[enq_cls] + 1'b1;
      end
      if (ctrl_o.rd_en) begin
        class_count_q[deq_cls] <= class_count_q[deq_cls] - 1'b1;
        class_head_q[deq_cls]  <= (class_head_q[deq_cls] == PTRW'(ClassDepth - 1))
                                  ? '0 : class_head_q[deq_cls] + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i && ctrl_o.wr_en && class_count_q[enq_cls] == '0) begin
      class_order_q[order_tail] <= enq_cls;
    end
  end

endmodule

// ===== rtl/class_grouped_fifo.sv =====
// A dequeue result, or a drop or empty report, appears in the cycle after its transfer.
// Throughput: one request per cycle; the input stalls only while a result waits on the output.
// A successful enqueue gives no result. Each request is at most one pointer update and at most one
// access to the item store memory.
// Reset clears valid, order pointers and class counts at once; stores need no clearing pass.
module class_grouped_fifo #(
  parameter int unsigned NUM_CLASSES = 5,
  parameter int unsigned CLASS_DEPTH = 16,
  parameter int unsigned VALUE_BITS  = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  cgf_pkg::cgf_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output cgf_pkg::cgf_out_t out_data_o
);

  localparam int unsigned StoreDepth = NUM_CLASSES * CLASS_DEPTH;
  localparam int unsigned AddrW      = $clog2(StoreDepth);
  localparam int unsigned DataW      = (VALUE_BITS < cgf_pkg::RollBits)
                                       ? VALUE_BITS : cgf_pkg::RollBits;

  cgf_pkg::cgf_ctrl_t ctrl;
  logic [AddrW-1:0]   wr_addr;
  logic [AddrW-1:0]   rd_addr;
  logic [DataW-1:0]   rd_data;
  logic               accept;

  logic                            out_valid_q;
  cgf_pkg::cgf_status_e            status_q;
  logic [cgf_pkg::ClassBits-1:0]   cls_q;
  logic [cgf_pkg::RollBits-1:0]    echo_roll_q;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  cgf_ctrl #(
    .NumClasses (NUM_CLASSES),
    .ClassDepth (CLASS_DEPTH),
    .AddrW      (AddrW)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .req_i     (in_data_i),
    .ctrl_o    (ctrl),
    .wr_addr_o (wr_addr),
    .rd_addr_o (rd_addr)
  );

  cgf_store #(
    .Depth (StoreDepth),
    .AddrW (AddrW),
    .DataW (DataW)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (accept && ctrl.wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (DataW'(in_data_i.roll_number)),
    .rd_en_i   (accept && ctrl.rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= ctrl.result;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Hold the report fields; the served value comes from the store read register
  always_ff @(posedge clk_i) begin
    if (accept && ctrl.result) begin
      status_q    <= ctrl.status;
      cls_q       <= ctrl.cls;
      echo_roll_q <= ctrl.echo_roll;
    end
  end

  always_comb begin
    out_data_o.out_class = cls_q;
    out_data_o.status    = status_q;
    out_data_o.out_roll  = (status_q == cgf_pkg::STATUS_SERVED)
                           ? cgf_pkg::RollBits'(rd_data) : echo_roll_q;
  end

  assign out_valid_o = out_valid_q;

  a_result_shows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && ctrl.result |=> out_valid_o)
    else $error("result of a transfer not presented");

  a_no_rw_clash : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctrl.wr_en && ctrl.rd_en))
    else $error("store written and read for one request");

  a_deq_reports : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_data_i.req_type == cgf_pkg::REQ_DEQ |-> ctrl.result)
    else $error("dequeue without a result");

  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without a waiting result");

endmodule

// ===== sim/class_grouped_fifo_tb.sv =====
`timescale 1ns / 100ps

module class_grouped_fifo_tb;

  localparam int unsigned NumClasses = 5;
  localparam int unsigned ClassDepth = 16;
  localparam int unsigned ValueBits  = 16;
  localparam int unsigned StallLimit = 1000;
  localparam int unsigned RandomReqs = 400;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready_o;
  cgf_pkg::cgf_in_t  in_data = '0;
  logic              out_valid_o;
  logic              out_ready = 1'b0;
  cgf_pkg::cgf_out_t out_data_o;

  class_grouped_fifo #(
    .NUM_CLASSES(NumClasses),
    .CLASS_DEPTH(ClassDepth),
    .VALUE_BITS (ValueBits)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready),
    .out_data_o (out_data_o)
  );

  always #6 clk_i = ~clk_i;

  // Shadow copy of the class queues
  logic [cgf_pkg::ClassBits-1:0] order_ring [NumClasses];
  int unsigned                   order_head;
  int unsigned                   order_fill;
  logic [cgf_pkg::RollBits-1:0]  roll_store [NumClasses][ClassDepth];
  int unsigned                   cls_head [NumClasses];
  int unsigned                   cls_fill [NumClasses];

  cgf_pkg::cgf_in_t  req_queue[$];
  cgf_pkg::cgf_out_t due_results[$];
  int unsigned errors;
  int unsigned reqs_sent;
  int unsigned results_seen;
  int unsigned n_served;
  int unsigned n_empty;
  int unsigned n_dropped;
  int unsigned in_wait;
  int unsigned out_wait;
  int unsigned stall_cycles;

  function automatic int unsigned pick_wait(int unsigned n);
    // every third stretch of transfers runs flat out
    if ((n / 48) % 3 == 1) return 0;
    return $urandom_range(0, 16);
  endfunction

  function automatic void serve_request(cgf_pkg::cgf_in_t req);
    cgf_pkg::cgf_out_t res;
    int unsigned       c;
    int unsigned       slot;
    res = '0;
    c = 32'(req.class_id);
    if (req.req_type == cgf_pkg::REQ_ENQ) begin
      if (c >= NumClasses || cls_fill[c] >= ClassDepth) begin
        res.out_class = req.class_id;
        res.out_roll  = req.roll_number;
        res.status    = cgf_pkg::STATUS_DROPPED;
        due_results = {due_results, res};
      end else begin
        slot = (cls_head[c] + cls_fill[c]) % ClassDepth;
        roll_store[c][slot] = req.roll_number;
        if (cls_fill[c] == 0) begin
          order_ring[(order_head + order_fill) % NumClasses] = c[cgf_pkg::ClassBits-1:0];
          order_fill++;
        end
        cls_fill[c]++;
      end
    end else if (order_fill == 0) begin
      res.status = cgf_pkg::STATUS_EMPTY;
      due_results = {due_results, res};
    end else begin
      c = 32'(order_ring[order_head]);
      res.out_class = c[cgf_pkg::ClassBits-1:0];
      res.out_roll  = roll_store[c][cls_head[c]];
      res.status    = cgf_pkg::STATUS_SERVED;
      cls_head[c] = (cls_head[c] + 1) % ClassDepth;
      cls_fill[c]--;
      // class leaves the order ring once drained
      if (cls_fill[c] == 0) begin
        order_head = (order_head + 1) % NumClasses;
        order_fill--;
      end
      due_results = {due_results, res};
    end
  endfunction

  task automatic queue_enq(int unsigned c, int unsigned v);
    cgf_pkg::cgf_in_t req;
    req.req_type    = cgf_pkg::REQ_ENQ;
    req.class_id    = c[cgf_pkg::ClassBits-1:0];
    req.roll_number = v[cgf_pkg::RollBits-1:0];
    req_queue = {req_queue, req};
  endtask

  task automatic queue_deq();
    cgf_pkg::cgf_in_t req;
    // payload fields carry noise; the block must ignore them
    req.req_type    = cgf_pkg::REQ_DEQ;
    req.class_id    = cgf_pkg::ClassBits'($urandom_range(0, 7));
    req.roll_number = cgf_pkg::RollBits'($urandom_range(0, 65535));
    req_queue = {req_queue, req};
  endtask

  function automatic int unsigned any_roll();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return 65535;
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  // Request driver
  always @(posedge clk_i or negedge rst_ni) begin : drive_requests
    logic fire;
    logic next_valid;
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_data  <= '0;
      in_wait  = 0;
    end else begin
      fire = in_valid && in_ready_o;
      next_valid = in_valid && !fire;
      if (fire) begin
        serve_request(in_data);
        reqs_sent++;
        in_wait = pick_wait(reqs_sent);
      end
      if (!next_valid && req_queue.size() != 0) begin
        if (in_wait == 0) begin
          next_valid = 1'b1;
          in_data <= req_queue[0];
          req_queue.delete(0);
        end else begin
          in_wait--;
        end
      end
      in_valid <= next_valid;
    end
  end

  // Result monitor
  always @(posedge clk_i or negedge rst_ni) begin : check_results
    cgf_pkg::cgf_out_t want;
    if (!rst_ni) begin
      out_ready <= 1'b0;
      out_wait  = 0;
    end else begin
      if (out_valid_o && out_ready) begin
        results_seen++;
        case (out_data_o.status)
          cgf_pkg::STATUS_SERVED:  n_served++;
          cgf_pkg::STATUS_EMPTY:   n_empty++;
          cgf_pkg::STATUS_DROPPED: n_dropped++;
          default: ;
        endcase
        if (due_results.size() == 0) begin
          $error("unexpected result: class %0d roll %0h status %0d",
                 out_data_o.out_class, out_data_o.out_roll, out_data_o.status);
          errors++;
        end else begin
          want = due_results[0];
          due_results.delete(0);
          if (out_data_o.out_class !== want.out_class) begin
            $error("out_class: expected %0d, got %0d", want.out_class, out_data_o.out_class);
            errors++;
          end
          if (out_data_o.out_roll !== want.out_roll) begin
            $error("out_roll: expected %0h, got %0h", want.out_roll, out_data_o.out_roll);
            errors++;
          end
          if (out_data_o.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_data_o.status);
            errors++;
          end
        end
        out_wait = pick_wait(results_seen);
      end
      // hold ready low while a stall is pending; it counts down only while a result waits
      if (out_wait != 0) begin
        if (out_valid_o) out_wait--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && in_ready_o) || (out_valid_o && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : stimulus
    int unsigned c;
    int unsigned n;
    order_head = 0;
    order_fill = 0;
    for (int i = 0; i < NumClasses; i++) begin
      cls_head[i] = 0;
      cls_fill[i] = 0;
    end

    // Directed: empty read, every class, bad classes, rejoin after drain
    queue_deq();
    queue_enq(0, 16'h0000);
    queue_enq(1, 16'hFFFF);
    queue_enq(2, 16'h5555);
    queue_enq(3, 16'hAAAA);
    queue_enq(4, 16'h1234);
    queue_enq(1, 16'h8001);
    queue_enq(5, 16'hFFFF);
    queue_enq(7, 16'h0000);
    queue_enq(6, 16'h7FFE);
    repeat (3) queue_deq();
    queue_enq(0, 16'hC3C3);
    repeat (5) queue_deq();

    // Random: bursts that fill a class past its depth, drains, and mixed traffic
    while (req_queue.size() < RandomReqs + 20) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          c = $urandom_range(0, NumClasses - 1);
          n = $urandom_range(ClassDepth - 2, ClassDepth + 3);
          repeat (n) queue_enq(c, any_roll());
        end
        2, 3: begin
          n = $urandom_range(1, 24);
          repeat (n) queue_deq();
        end
        default: begin
          n = $urandom_range(1, 8);
          repeat (n) begin
            if ($urandom_range(0, 9) < 6) begin
              if ($urandom_range(0, 11) == 0) c = $urandom_range(NumClasses, 7);
              else c = $urandom_range(0, NumClasses - 1);
              queue_enq(c, any_roll());
            end else begin
              queue_deq();
            end
          end
        end
      endcase
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (req_queue.size() == 0 && !in_valid);
    wait (due_results.size() == 0);
    repeat (8) @(posedge clk_i);

    if (due_results.size() != 0) begin
      $error("%0d results never arrived", due_results.size());
      errors++;
    end
    $display("Sent %0d requests, checked %0d results", reqs_sent, results_seen);
    $display("  served %0d, empty reads %0d, drops %0d", n_served, n_empty, n_dropped);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
